>>> design/ckpd_pkg.sv
// Shared types, operation codes and status codes for the priority dispatcher.
`timescale 1ns / 1ps

package ckpd_pkg;

    // Default sizes handed to the top level.
    localparam int TABLE_DEPTH_DEF = 32;
    localparam int MAX_SERVE_DEF   = 16;

    // Operation codes carried on mode.
    localparam logic [1:0] MODE_ADMIT    = 2'd0;
    localparam logic [1:0] MODE_UPDATE   = 2'd1;
    localparam logic [1:0] MODE_DISPATCH = 2'd2;

    // Result status codes.
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
    localparam logic [2:0] STAT_ALREADY   = 3'd2;
    localparam logic [2:0] STAT_FULL      = 3'd3;
    localparam logic [2:0] STAT_NONE      = 3'd4;

    // One table entry as held in the entry memory.
    typedef struct packed {
        logic        served;
        logic [15:0] id;
        logic [1:0]  cls;
        logic [10:0] arrival;
        logic [7:0]  age;
    } entry_t;

    // Result of one pass through the shared compare unit.
    typedef struct packed {
        logic id_hit;
        logic wins;
    } cmp_t;

endpackage

>>> design/ckpd_rank_unit.sv
// Shared compare unit: id match and three-level priority ranking of two entries.
`timescale 1ns / 1ps

module ckpd_rank_unit
    import ckpd_pkg::*;
(
    input  entry_t      cand,
    input  entry_t      best,
    input  logic [15:0] key_id,
    output cmp_t        result
);

    // Lowest class first, then earliest arrival, then greatest age.
    always_comb
    begin
        result.id_hit = (cand.id == key_id);
        if (cand.cls != best.cls)
        begin
            result.wins = (cand.cls < best.cls);
        end
        else if (cand.arrival != best.arrival)
        begin
            result.wins = (cand.arrival < best.arrival);
        end
        else
        begin
            result.wins = (cand.age > best.age);
        end
    end

endmodule

>>> design/composite_key_priority_dispatcher_top.sv
// Top level of the priority dispatcher: entry memory, scan sequencer and result register.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// command   in         start and not busy        mode, request_id, urgency_class,
//                                                arrival_stamp, age_years, servers_free
// result    out        strobe, one cycle each    status, served_id, last
//
// Admit, update and dispatch scan the filled part of the table once per step, one entry per
// cycle through the single read port and the shared compare unit.
// Admit and update give one result after the scan. Dispatch gives one result per served
// item and scans again for each; mode 3 gives no result, and a dispatch of zero reports
// none without a scan. Reset empties the table at once through the fill count.
// Results cannot be held off; busy stays high until the last result of an item.

module composite_key_priority_dispatcher_top
    import ckpd_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_SERVE   = MAX_SERVE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [15:0] request_id,
    input  logic [1:0]  urgency_class,
    input  logic [10:0] arrival_stamp,
    input  logic [7:0]  age_years,
    input  logic [4:0]  servers_free,
    output logic        strobe,
    output logic [2:0]  status,
    output logic [15:0] served_id,
    output logic        last
);

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W  = $clog2(MAX_SERVE + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    // Entry memory.
    entry_t mem [TABLE_DEPTH];

    logic [1:0]        state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic [15:0]       id_reg, id_next;
    logic [1:0]        cls_reg, cls_next;
    logic [10:0]       arr_reg, arr_next;
    logic [7:0]        age_reg, age_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] issue_reg, issue_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    entry_t            rd_data_reg;
    logic              rd_en;
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    entry_t            hit_data_reg, hit_data_next;
    logic              best_vld_reg, best_vld_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    entry_t            best_data_reg, best_data_next;
    logic [FILL_W-1:0] wait_cnt_reg, wait_cnt_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  want_reg, want_next;
    logic              strobe_reg, strobe_next;
    logic [2:0]        status_reg, status_next;
    logic [15:0]       served_id_reg, served_id_next;
    logic              last_reg, last_next;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    cmp_t              cmp;
    logic              serve_last;

    // Shared compare unit sees the entry just read and the best one so far.
    ckpd_rank_unit u_rank (
        .cand   (rd_data_reg),
        .best   (best_data_reg),
        .key_id (id_reg),
        .result (cmp)
    );

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[issue_reg[IDX_W-1:0]];
        end
    end

    // The item served now is the final one if the count is met or nothing else waits.
    assign serve_last = (CNT_W'(k_reg + 1'b1) == want_reg) || (wait_cnt_reg == FILL_W'(1));

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        cls_next       = cls_reg;
        arr_next       = arr_reg;
        age_next       = age_reg;
        fill_next      = fill_reg;
        issue_next     = issue_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        rd_en          = 1'b0;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_data_next  = hit_data_reg;
        best_vld_next  = best_vld_reg;
        best_idx_next  = best_idx_reg;
        best_data_next = best_data_reg;
        wait_cnt_next  = wait_cnt_reg;
        k_next         = k_reg;
        want_next      = want_reg;
        strobe_next    = 1'b0;
        status_next    = status_reg;
        served_id_next = served_id_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;
        wr_addr        = hit_idx_reg;
        wr_data        = hit_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next       = mode;
                    id_next       = request_id;
                    cls_next      = urgency_class;
                    arr_next      = arrival_stamp;
                    age_next      = age_years;
                    issue_next    = '0;
                    hit_next      = 1'b0;
                    best_vld_next = 1'b0;
                    wait_cnt_next = '0;
                    k_next        = '0;
                    if (32'(servers_free) > MAX_SERVE)
                    begin
                        want_next = CNT_W'(MAX_SERVE);
                    end
                    else
                    begin
                        want_next = CNT_W'(servers_free);
                    end
                    if (mode == MODE_ADMIT || mode == MODE_UPDATE)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (mode == MODE_DISPATCH)
                    begin
                        if (servers_free == 5'd0)
                        begin
                            strobe_next    = 1'b1;
                            status_next    = STAT_NONE;
                            served_id_next = '0;
                            last_next      = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                // Issue the next read while slots remain.
                if (issue_reg != fill_reg)
                begin
                    rd_en       = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = issue_reg[IDX_W-1:0];
                    issue_next  = FILL_W'(issue_reg + 1'b1);
                end
                // Look at the entry read in the cycle before.
                if (rd_vld_reg)
                begin
                    if (cmp.id_hit && !hit_reg)
                    begin
                        hit_next      = 1'b1;
                        hit_idx_next  = rd_idx_reg;
                        hit_data_next = rd_data_reg;
                    end
                    if (!rd_data_reg.served)
                    begin
                        wait_cnt_next = FILL_W'(wait_cnt_reg + 1'b1);
                        if (!best_vld_reg || cmp.wins)
                        begin
                            best_vld_next  = 1'b1;
                            best_idx_next  = rd_idx_reg;
                            best_data_next = rd_data_reg;
                        end
                    end
                end
                if (issue_reg == fill_reg && !rd_vld_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                strobe_next    = 1'b1;
                served_id_next = id_reg;
                last_next      = 1'b1;
                state_next     = ST_IDLE;
                case (op_reg)
                    MODE_ADMIT:
                    begin
                        wr_data.served  = 1'b0;
                        wr_data.id      = id_reg;
                        wr_data.cls     = cls_reg;
                        wr_data.arrival = arr_reg;
                        wr_data.age     = age_reg;
                        status_next     = STAT_OK;
                        if (hit_reg)
                        begin
                            wr_en = 1'b1;
                        end
                        else if (fill_reg < FILL_W'(TABLE_DEPTH))
                        begin
                            wr_en     = 1'b1;
                            wr_addr   = fill_reg[IDX_W-1:0];
                            fill_next = FILL_W'(fill_reg + 1'b1);
                        end
                        else
                        begin
                            status_next = STAT_FULL;
                        end
                    end

                    MODE_UPDATE:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = STAT_NOT_FOUND;
                        end
                        else if (hit_data_reg.served)
                        begin
                            status_next = STAT_ALREADY;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            wr_data.cls = cls_reg;
                            status_next = STAT_OK;
                        end
                    end

                    default:
                    begin
                        // Dispatch: serve the best waiting entry, or report none.
                        if (!best_vld_reg)
                        begin
                            status_next    = STAT_NONE;
                            served_id_next = '0;
                        end
                        else
                        begin
                            wr_en          = 1'b1;
                            wr_addr        = best_idx_reg;
                            wr_data        = best_data_reg;
                            wr_data.served = 1'b1;
                            status_next    = STAT_OK;
                            served_id_next = best_data_reg.id;
                            last_next      = serve_last;
                            if (!serve_last)
                            begin
                                k_next        = CNT_W'(k_reg + 1'b1);
                                issue_next    = '0;
                                best_vld_next = 1'b0;
                                wait_cnt_next = '0;
                                state_next    = ST_SCAN;
                            end
                        end
                    end
                endcase
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            strobe_reg   <= 1'b0;
            hit_reg      <= 1'b0;
            best_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            rd_vld_reg   <= rd_vld_next;
            strobe_reg   <= strobe_next;
            hit_reg      <= hit_next;
            best_vld_reg <= best_vld_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        id_reg        <= id_next;
        cls_reg       <= cls_next;
        arr_reg       <= arr_next;
        age_reg       <= age_next;
        issue_reg     <= issue_next;
        rd_idx_reg    <= rd_idx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_data_reg  <= hit_data_next;
        best_idx_reg  <= best_idx_next;
        best_data_reg <= best_data_next;
        wait_cnt_reg  <= wait_cnt_next;
        k_reg         <= k_next;
        want_reg      <= want_next;
        status_reg    <= status_next;
        served_id_reg <= served_id_next;
        last_reg      <= last_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign strobe    = strobe_reg;
    assign status    = status_reg;
    assign served_id = served_id_reg;
    assign last      = last_reg;

`ifndef NO_ASSERTIONS
    // The fill count never runs past the table.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // A "none served" item is always final and carries id zero.
    a_none_form: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status == STAT_NONE |-> last && served_id == 16'd0)
        else $error("malformed none-served item");

    // A result that is not final means the dispatch is still scanning.
    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("non-final item with block idle");

    // A dispatch scan never starts once the serve count is met.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && op_reg == MODE_DISPATCH |-> k_reg < want_reg)
        else $error("dispatch scan beyond serve count");

    // Read data only arrives during a scan.
    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> state_reg == ST_SCAN)
        else $error("read data outside a scan");
`endif

endmodule
